FILE: rtl/ghp_pkg.sv
// ============================================================================
// ghp_pkg: shared types and constants for the gzip header parser
// Holds the parse phase encoding, status codes, header constants and the
// result record passed between the parser and the output register.
// ============================================================================
package ghp_pkg;

    localparam int unsigned OffsetW = 17;
    localparam int unsigned LengthW = 32;
    localparam int unsigned StatusW = 3;

    localparam logic [7:0] MagicA        = 8'h1f;
    localparam logic [7:0] MagicB        = 8'h8b;
    localparam logic [7:0] MethodDeflate = 8'd8;

    // Bit positions in the FLG byte.
    localparam int unsigned FlgHcrc      = 1;
    localparam int unsigned FlgExtra     = 2;
    localparam int unsigned FlgName      = 3;
    localparam int unsigned FlgComment   = 4;
    localparam int unsigned FlgEncrypted = 5;

    // Offset of the last fixed header byte (OS field).
    localparam logic [OffsetW-1:0] LastFixedOffset = 17'd9;
    localparam logic [OffsetW:0]   TrailerBytes    = 18'd8;

    typedef enum logic [StatusW-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_MAGIC   = 3'd1,
        ST_BAD_METHOD  = 3'd2,
        ST_ENCRYPTED   = 3'd3,
        ST_HDR_TOO_BIG = 3'd4,
        ST_FILE_SHORT  = 3'd5
    } t_status;

    typedef enum logic [13:0] {
        PH_IDLE    = 14'b00000000000001,
        PH_MAGIC0  = 14'b00000000000010,
        PH_MAGIC1  = 14'b00000000000100,
        PH_METHOD  = 14'b00000000001000,
        PH_FLAGS   = 14'b00000000010000,
        PH_FIXED   = 14'b00000000100000,
        PH_XLEN_LO = 14'b00000001000000,
        PH_XLEN_HI = 14'b00000010000000,
        PH_EXTRA   = 14'b00000100000000,
        PH_NAME    = 14'b00001000000000,
        PH_COMMENT = 14'b00010000000000,
        PH_CRC0    = 14'b00100000000000,
        PH_CRC1    = 14'b01000000000000,
        PH_DONE    = 14'b10000000000000
    } t_phase;

    typedef struct packed {
        t_status              status;
        logic [OffsetW-1:0]   body_offset;
        logic [LengthW-1:0]   body_length;
    } t_result;

endpackage

FILE: rtl/ghp_parser.sv
// ============================================================================
// ghp_parser: header parse state machine
// Consumes one registered byte per fire, updates the parse state and forms
// the single result when the header ends or an error shows up.
// ============================================================================
module ghp_parser #(
    parameter int unsigned MAX_HEADER_BYTES = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_first_byte,
    input  logic [ghp_pkg::LengthW-1:0]   i_file_length,
    output logic                          o_res_valid,
    output ghp_pkg::t_result              o_res
);
    import ghp_pkg::*;

    localparam logic [OffsetW-1:0] HdrLimit = OffsetW'(MAX_HEADER_BYTES);

    t_phase               r_phase, n_phase;
    logic [OffsetW-1:0]   r_off, n_off;
    logic [7:0]           r_flags, n_flags;
    logic [15:0]          r_extra, n_extra;

    t_phase               cur_phase;
    logic [OffsetW-1:0]   cur_off;
    logic [7:0]           cur_flags;
    logic [15:0]          cur_extra;
    logic [15:0]          ext_val;
    logic [OffsetW:0]     end_plus_trailer;
    logic                 file_short;
    logic                 do_finish;
    logic                 do_error;
    t_status              err_code;
    t_phase               adv_phase;

    // First flagged optional part at or after the given point; PH_DONE means
    // the header is complete.
    function automatic t_phase f_advance(input logic [7:0] flags, input logic chk_extra,
                                         input logic chk_name, input logic chk_comment);
        t_phase ph;
        if (chk_extra && flags[FlgExtra]) begin
            ph = PH_XLEN_LO;
        end else if (chk_name && flags[FlgName]) begin
            ph = PH_NAME;
        end else if (chk_comment && flags[FlgComment]) begin
            ph = PH_COMMENT;
        end else if (flags[FlgHcrc]) begin
            ph = PH_CRC0;
        end else begin
            ph = PH_DONE;
        end
        return ph;
    endfunction

    always_comb begin
        cur_phase = i_first_byte ? PH_MAGIC0 : r_phase;
        cur_off   = i_first_byte ? '0 : r_off;
        cur_flags = i_first_byte ? '0 : r_flags;
        cur_extra = i_first_byte ? '0 : r_extra;

        n_phase   = cur_phase;
        n_off     = cur_off;
        n_flags   = cur_flags;
        n_extra   = cur_extra;
        do_finish = 1'b0;
        do_error  = 1'b0;
        err_code  = ST_OK;
        adv_phase = PH_DONE;
        ext_val   = {i_data_byte, cur_extra[7:0]};

        if (cur_phase != PH_IDLE && cur_phase != PH_DONE) begin
            n_off = cur_off + 1'b1;
        end

        case (cur_phase)
            PH_MAGIC0: begin
                if (i_data_byte != MagicA) begin
                    do_error = 1'b1;
                    err_code = ST_BAD_MAGIC;
                end else begin
                    n_phase = PH_MAGIC1;
                end
            end
            PH_MAGIC1: begin
                if (i_data_byte != MagicB) begin
                    do_error = 1'b1;
                    err_code = ST_BAD_MAGIC;
                end else begin
                    n_phase = PH_METHOD;
                end
            end
            PH_METHOD: begin
                if (i_data_byte != MethodDeflate) begin
                    do_error = 1'b1;
                    err_code = ST_BAD_METHOD;
                end else begin
                    n_phase = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                n_flags = i_data_byte;
                if (i_data_byte[FlgEncrypted]) begin
                    do_error = 1'b1;
                    err_code = ST_ENCRYPTED;
                end else begin
                    n_phase = PH_FIXED;
                end
            end
            PH_FIXED: begin
                if (cur_off >= LastFixedOffset) begin
                    adv_phase = f_advance(cur_flags, 1'b1, 1'b1, 1'b1);
                    do_finish = (adv_phase == PH_DONE);
                    n_phase   = adv_phase;
                end
            end
            PH_XLEN_LO: begin
                n_extra = {8'd0, i_data_byte};
                n_phase = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
                n_extra = ext_val;
                if (ext_val == '0) begin
                    adv_phase = f_advance(cur_flags, 1'b0, 1'b1, 1'b1);
                    do_finish = (adv_phase == PH_DONE);
                    n_phase   = adv_phase;
                end else begin
                    n_phase = PH_EXTRA;
                end
            end
            PH_EXTRA: begin
                n_extra = cur_extra - 1'b1;
                if (cur_extra == 16'd1) begin
                    adv_phase = f_advance(cur_flags, 1'b0, 1'b1, 1'b1);
                    do_finish = (adv_phase == PH_DONE);
                    n_phase   = adv_phase;
                end
            end
            PH_NAME: begin
                if (cur_off >= HdrLimit) begin
                    do_error = 1'b1;
                    err_code = ST_HDR_TOO_BIG;
                end else if (i_data_byte == 8'd0) begin
                    adv_phase = f_advance(cur_flags, 1'b0, 1'b0, 1'b1);
                    do_finish = (adv_phase == PH_DONE);
                    n_phase   = adv_phase;
                end
            end
            PH_COMMENT: begin
                if (cur_off >= HdrLimit) begin
                    do_error = 1'b1;
                    err_code = ST_HDR_TOO_BIG;
                end else if (i_data_byte == 8'd0) begin
                    adv_phase = f_advance(cur_flags, 1'b0, 1'b0, 1'b0);
                    do_finish = (adv_phase == PH_DONE);
                    n_phase   = adv_phase;
                end
            end
            PH_CRC0: begin
                n_phase = PH_CRC1;
            end
            PH_CRC1: begin
                do_finish = 1'b1;
                n_phase   = PH_DONE;
            end
            PH_IDLE, PH_DONE: begin
                n_phase = cur_phase;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (do_error) begin
            n_phase = PH_DONE;
        end

        // Payload starts right after the byte that closed the header.
        end_plus_trailer = {1'b0, n_off} + TrailerBytes;
        file_short = i_file_length < LengthW'(end_plus_trailer);

        o_res_valid = do_error || do_finish;
        if (do_error) begin
            o_res.status      = err_code;
            o_res.body_offset = '0;
            o_res.body_length = '0;
        end else if (file_short) begin
            o_res.status      = ST_FILE_SHORT;
            o_res.body_offset = n_off;
            o_res.body_length = '0;
        end else begin
            o_res.status      = ST_OK;
            o_res.body_offset = n_off;
            o_res.body_length = i_file_length - LengthW'(end_plus_trailer);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_off   <= '0;
            r_flags <= '0;
            r_extra <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_flags <= n_flags;
            r_extra <= n_extra;
        end
    end

endmodule

FILE: rtl/ghp_out_reg.sv
// ============================================================================
// ghp_out_reg: result register
// Holds one result until the downstream side takes it and tells the parse
// stage whether a new result can be written this cycle.
// ============================================================================
module ghp_out_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  ghp_pkg::t_result              i_res,
    input  logic                          i_stall,
    output logic                          o_free,
    output logic                          o_valid,
    output logic [ghp_pkg::StatusW-1:0]   o_status,
    output logic [ghp_pkg::OffsetW-1:0]   o_body_offset,
    output logic [ghp_pkg::LengthW-1:0]   o_body_length
);
    import ghp_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_res.status;
    assign o_body_offset = r_res.body_offset;
    assign o_body_length = r_res.body_length;

endmodule

FILE: rtl/gzip_header_parser.sv
// ============================================================================
// gzip_header_parser: gzip member header parser
// Walks the header of a gzip file one byte per beat and reports where the
// deflate payload starts and how long it is.
// ============================================================================
// Feed the file bytes in order with i_first_byte set on the byte at offset
// zero; that byte restarts the parse from any state. The block checks the
// magic bytes and the deflate method, rejects the encrypted flag, and skips
// the fixed fields, the optional extra field, the zero-terminated name and
// comment and the header CRC. On the byte that closes the header, or on the
// first byte that shows an error, one result beat comes out; after that all
// bytes are ignored until the next start byte. A header that never closes
// gives no result. Bytes are taken at one per clock: an accepted beat sits
// in the input register while the parse logic works on it, and its
// result is written into the output register at the edge on which the
// parse stage fires, after which it is offered downstream.
// The rate drops only while a held result is stalled by the downstream
// side. Write i_cfg_file_length with the total file size before the file
// is streamed; it is used to derive the payload size (file size minus
// payload start minus the 8 byte trailer), and a file too short for that
// gives the file-too-short status with a size of zero. MAX_HEADER_BYTES
// bounds the offset at which a name or comment byte may still arrive.
// ============================================================================
module gzip_header_parser #(
    parameter int unsigned MAX_HEADER_BYTES = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ghp_pkg::LengthW-1:0]   i_cfg_file_length,
    // Byte input channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_first_byte,
    // Result output channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ghp_pkg::StatusW-1:0]   o_status,
    output logic [ghp_pkg::OffsetW-1:0]   o_body_offset,
    output logic [ghp_pkg::LengthW-1:0]   o_body_length
);
    import ghp_pkg::*;

    logic                 r_file_length;
    logic [LengthW-1:0]   r_len;
    logic                 r_in_valid, n_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_first;
    logic                 in_accept;
    logic                 out_free;
    logic                 fire;
    logic                 res_valid;
    t_result              res;

    // The register can be written at any time; the user only writes it
    // while no file is in flight.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len         <= '0;
            r_file_length <= 1'b0;
        end else if (i_cfg_valid) begin
            r_len         <= i_cfg_file_length;
            r_file_length <= 1'b1;
        end
    end

    // The parse stage advances whenever the result register can take a new
    // value this cycle, so a held input beat only waits on a stalled result.
    assign fire      = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    always_comb begin
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_byte;
        end
    end

    ghp_parser #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_data_byte   (r_in_byte),
        .i_first_byte  (r_in_first),
        .i_file_length (r_file_length ? r_len : '0),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    ghp_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (fire && res_valid),
        .i_res         (res),
        .i_stall       (i_stall),
        .o_free        (out_free),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_body_offset (o_body_offset),
        .o_body_length (o_body_length)
    );

endmodule

FILE: dv/gzip_header_parser_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// gzip_header_parser_tb: self-checking testbench for the gzip header parser
// Streams gzip headers byte by byte, some of them well formed and some broken
// or cut short, and checks every result beat against a predictor. Both sides
// of the block idle and stall at random, and the file length register is
// changed between phases of the run.
// ============================================================================
module gzip_header_parser_tb;

    import ghp_pkg::*;

    localparam int unsigned HalfPeriod  = 5;
    localparam int unsigned HdrLimit    = 512;
    localparam int unsigned ByteTarget  = 1550;
    localparam int unsigned PhaseCount  = 6;
    // A result leaves after its byte has passed the input and output registers;
    // the rest of this wait covers bytes that give no result before a register write or the end of the run.
    localparam int unsigned DrainCycles = 6;
    // The quietest stretch of a correct run is a gap or stall streak or a drain
    // wait, which this limit exceeds by a wide margin.
    localparam int unsigned QuietLimit  = 1000;

    typedef struct {
        logic [7:0] data;
        logic       first;
    } t_file_byte;

    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_cfg_valid       = 1'b0;
    logic                 o_cfg_ready;
    logic [LengthW-1:0]   i_cfg_file_length = '0;
    logic                 i_valid           = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_data_byte       = '0;
    logic                 i_first_byte      = 1'b0;
    logic                 o_valid;
    logic                 i_stall           = 1'b0;
    logic [StatusW-1:0]   o_status;
    logic [OffsetW-1:0]   o_body_offset;
    logic [LengthW-1:0]   o_body_length;

    gzip_header_parser #(
        .MAX_HEADER_BYTES (HdrLimit)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_file_length (i_cfg_file_length),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_first_byte      (i_first_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_body_offset     (o_body_offset),
        .o_body_length     (o_body_length)
    );

    always #(HalfPeriod) i_clk = ~i_clk;

    // Bytes waiting to be driven, and result beats the predictor has formed
    // that the block has not yet delivered.
    t_file_byte byte_q[$];
    t_result    pending_results[$];

    // Percent chance, per cycle, that the sender leaves a gap or the receiver
    // stalls. Changed only at the falling edge.
    int unsigned gap_pct   = 32;
    int unsigned stall_pct = 32;

    int unsigned header_bytes  = 0;
    int unsigned files_queued  = 0;
    int unsigned mismatches    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned status_seen[0:7];

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the register and the parse state.
    // ------------------------------------------------------------------------
    logic [LengthW-1:0] file_len_cfg = '0;
    t_phase             hdr_phase    = PH_IDLE;
    logic [OffsetW-1:0] hdr_offset   = '0;
    logic [7:0]         hdr_flags    = '0;
    logic [15:0]        extra_left   = '0;

    // Records the one result of the current header; the parse then ignores
    // bytes until the next start byte.
    function automatic void post_result(input t_status st, input logic [OffsetW-1:0] start,
                                        input logic [LengthW-1:0] size);
        t_result res;
        res.status      = st;
        res.body_offset = start;
        res.body_length = size;
        pending_results.push_back(res);
        hdr_phase = PH_DONE;
    endfunction

    // The header has closed at hdr_offset. The payload is whatever lies
    // between it and the 8 byte trailer; a file with no room for that is short.
    function automatic void close_header();
        logic [LengthW+1:0] needed;
        needed = (LengthW + 2)'(hdr_offset) + (LengthW + 2)'(TrailerBytes);
        if ((LengthW + 2)'(file_len_cfg) < needed) begin
            post_result(ST_FILE_SHORT, hdr_offset, '0);
        end else begin
            post_result(ST_OK, hdr_offset,
                        file_len_cfg - LengthW'(hdr_offset) - LengthW'(TrailerBytes));
        end
    endfunction

    // Moves to the first optional part, at or after the one given, whose flag
    // is set. The one-hot phase codes rise in header order, so a plain
    // comparison tells which parts are still ahead.
    function automatic void next_optional(input t_phase from);
        if (from <= PH_XLEN_LO && hdr_flags[FlgExtra]) begin
            hdr_phase = PH_XLEN_LO;
        end else if (from <= PH_NAME && hdr_flags[FlgName]) begin
            hdr_phase = PH_NAME;
        end else if (from <= PH_COMMENT && hdr_flags[FlgComment]) begin
            hdr_phase = PH_COMMENT;
        end else if (from <= PH_CRC0 && hdr_flags[FlgHcrc]) begin
            hdr_phase = PH_CRC0;
        end else begin
            close_header();
        end
    endfunction

    // Advances the parse by one accepted byte.
    function automatic void parse_gzip_byte(input logic [7:0] b, input logic first);
        logic [OffsetW-1:0] pos;
        // A start byte drops whatever parse was under way.
        if (first) begin
            hdr_phase  = PH_MAGIC0;
            hdr_offset = '0;
            hdr_flags  = '0;
            extra_left = '0;
        end
        if (hdr_phase == PH_IDLE || hdr_phase == PH_DONE) begin
            return;
        end
        pos        = hdr_offset;
        hdr_offset = pos + 1'b1;
        case (hdr_phase)
            PH_MAGIC0: begin
                if (b != MagicA) post_result(ST_BAD_MAGIC, '0, '0);
                else hdr_phase = PH_MAGIC1;
            end
            PH_MAGIC1: begin
                if (b != MagicB) post_result(ST_BAD_MAGIC, '0, '0);
                else hdr_phase = PH_METHOD;
            end
            PH_METHOD: begin
                if (b != MethodDeflate) post_result(ST_BAD_METHOD, '0, '0);
                else hdr_phase = PH_FLAGS;
            end
            PH_FLAGS: begin
                hdr_flags = b;
                if (b[FlgEncrypted]) post_result(ST_ENCRYPTED, '0, '0);
                else hdr_phase = PH_FIXED;
            end
            PH_FIXED: begin
                if (pos >= LastFixedOffset) next_optional(PH_XLEN_LO);
            end
            PH_XLEN_LO: begin
                extra_left = {8'h00, b};
                hdr_phase  = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
                extra_left[15:8] = b;
                if (extra_left == '0) next_optional(PH_NAME);
                else hdr_phase = PH_EXTRA;
            end
            PH_EXTRA: begin
                extra_left = extra_left - 1'b1;
                if (extra_left == '0) next_optional(PH_NAME);
            end
            PH_NAME: begin
                if (pos >= HdrLimit) post_result(ST_HDR_TOO_BIG, '0, '0);
                else if (b == 8'h00) next_optional(PH_COMMENT);
            end
            PH_COMMENT: begin
                if (pos >= HdrLimit) post_result(ST_HDR_TOO_BIG, '0, '0);
                else if (b == 8'h00) next_optional(PH_CRC0);
            end
            PH_CRC0: begin
                hdr_phase = PH_CRC1;
            end
            PH_CRC1: begin
                close_header();
            end
            default: begin
                hdr_phase = PH_IDLE;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver. A beat that is offered stays put until the block takes it; only
    // then may the next byte be offered or a gap be left. The gap decision
    // never looks at o_stall.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_gzip_byte(i_data_byte, i_first_byte);
            end
            if (!i_valid || !o_stall) begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    i_valid      <= 1'b1;
                    i_data_byte  <= byte_q[0].data;
                    i_first_byte <= byte_q[0].first;
                    void'(byte_q.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each result beat is matched against the oldest prediction.
    // ------------------------------------------------------------------------
    function automatic void check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: result beat with none expected: status %0d start %0d size %0d",
                     $time, o_status, o_body_offset, o_body_length);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        if (o_status != want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, o_status);
            mismatches++;
        end
        if (o_body_offset != want.body_offset) begin
            $display("%0t: payload start expected %0d, actual %0d",
                     $time, want.body_offset, o_body_offset);
            mismatches++;
        end
        if (o_body_length != want.body_length) begin
            $display("%0t: payload size expected %0d, actual %0d",
                     $time, want.body_length, o_body_length);
            mismatches++;
        end
        status_seen[o_status]++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                check_result();
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: the run is stuck if no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("%0t: no beat accepted for %0d cycles", $time, QuietLimit);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Queues are filled at the falling edge so that the
    // driver never races the generator.
    // ------------------------------------------------------------------------

    // Waits until every byte is taken and every result has come, then lets
    // the pipeline drain bytes that give no result.
    task automatic wait_for_idle();
        while (byte_q.size() != 0 || i_valid || pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_file_length(input logic [LengthW-1:0] len);
        @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_file_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        file_len_cfg = len;
        @(negedge i_clk);
    endtask

    // Bytes with no start mark while the parser waits; they give no result.
    task automatic queue_noise(input int unsigned count);
        t_file_byte fb;
        repeat (count) begin
            fb.data  = 8'($urandom);
            fb.first = 1'b0;
            byte_q.push_back(fb);
        end
    endtask

    // Builds one header from its fields and queues its first 'keep' bytes
    // (all of them when keep is 0), with the start mark on the first.
    task automatic queue_header(input logic [7:0] id1, input logic [7:0] id2,
                                input logic [7:0] cm, input logic [7:0] flg,
                                input int unsigned xlen, input int unsigned name_len,
                                input int unsigned note_len, input int unsigned keep);
        logic [7:0]  hdr[$];
        t_file_byte  fb;
        int unsigned count;
        int unsigned i;
        hdr.push_back(id1);
        hdr.push_back(id2);
        hdr.push_back(cm);
        hdr.push_back(flg);
        // Modification time, extra flags and OS.
        repeat (6) hdr.push_back(8'($urandom));
        if (flg[FlgExtra]) begin
            hdr.push_back(xlen[7:0]);
            hdr.push_back(xlen[15:8]);
            repeat (xlen) hdr.push_back(8'($urandom));
        end
        if (flg[FlgName]) begin
            repeat (name_len) hdr.push_back(8'($urandom_range(1, 255)));
            hdr.push_back(8'h00);
        end
        if (flg[FlgComment]) begin
            repeat (note_len) hdr.push_back(8'($urandom_range(1, 255)));
            hdr.push_back(8'h00);
        end
        if (flg[FlgHcrc]) begin
            repeat (2) hdr.push_back(8'($urandom));
        end
        count = (keep == 0 || keep > hdr.size()) ? hdr.size() : keep;
        for (i = 0; i < count; i++) begin
            fb.data  = hdr[i];
            fb.first = (i == 0);
            byte_q.push_back(fb);
        end
        header_bytes += count;
        files_queued++;
    endtask

    // One random file. Most are well formed with random content so that the
    // optional parts get exercised; the rest are cut short, oversized,
    // rejected early, or plain noise.
    task automatic queue_random_file();
        int unsigned roll;
        logic [7:0]  id1;
        logic [7:0]  id2;
        logic [7:0]  cm;
        logic [7:0]  flg;
        int unsigned xlen;
        int unsigned name_len;
        int unsigned note_len;
        int unsigned keep;
        roll     = $urandom_range(0, 99);
        id1      = MagicA;
        id2      = MagicB;
        cm       = MethodDeflate;
        flg      = 8'($urandom);
        flg[FlgEncrypted] = 1'b0;
        xlen     = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        name_len = $urandom_range(0, 8);
        note_len = $urandom_range(0, 8);
        keep     = 0;
        if (roll < 62) begin
            // Well formed, sizes as drawn.
        end else if (roll < 64) begin
            // Name ending right around the header limit.
            flg[FlgExtra]   = 1'b0;
            flg[FlgName]    = 1'b1;
            name_len        = $urandom_range(499, 504);
        end else if (roll < 66) begin
            // Comment ending right around the header limit.
            flg[FlgExtra]   = 1'b0;
            flg[FlgName]    = 1'b0;
            flg[FlgComment] = 1'b1;
            note_len        = $urandom_range(499, 504);
        end else if (roll < 68) begin
            // Extra field that runs up to or past the limit before the name.
            flg[FlgExtra]   = 1'b1;
            flg[FlgName]    = 1'b1;
            xlen            = $urandom_range(490, 520);
        end else if (roll < 78) begin
            // Header cut short; the next start byte restarts the parse.
            keep = $urandom_range(1, 12 + xlen + name_len + note_len);
        end else if (roll < 81) begin
            // Large extra length, cut short after a few extra bytes.
            flg[FlgExtra]   = 1'b1;
            xlen            = $urandom_range(256, 65535);
            keep            = $urandom_range(11, 40);
        end else if (roll < 84) begin
            id1 = MagicA ^ 8'($urandom_range(1, 255));
        end else if (roll < 87) begin
            id2 = MagicB ^ 8'($urandom_range(1, 255));
        end else if (roll < 90) begin
            cm = MethodDeflate ^ 8'($urandom_range(1, 255));
        end else if (roll < 93) begin
            flg[FlgEncrypted] = 1'b1;
        end else begin
            queue_noise($urandom_range(1, 4));
            return;
        end
        queue_header(id1, id2, cm, flg, xlen, name_len, note_len, keep);
        // Bytes after a finished header belong to the payload and are ignored.
        if ($urandom_range(0, 1) == 0) begin
            queue_noise($urandom_range(1, 3));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : run
        int unsigned phase;
        int unsigned half_mark;
        logic [LengthW-1:0] len;
        foreach (status_seen[k]) status_seen[k] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, run with the file length still at its reset value of
        // zero, so the one complete header comes out as a short file.
        queue_noise(1);                                                  // no start mark
        queue_header(8'h00, MagicB, MethodDeflate, 8'h00, 0, 0, 0, 1);   // bad first magic
        queue_header(MagicA, 8'hff, MethodDeflate, 8'h00, 0, 0, 0, 2);   // bad second magic
        queue_header(MagicA, MagicB, 8'h07, 8'h00, 0, 0, 0, 3);          // not deflate
        queue_header(MagicA, MagicB, MethodDeflate, 8'hff, 0, 0, 0, 4);  // encrypted
        queue_header(MagicA, MagicB, MethodDeflate, 8'h00, 0, 0, 0, 3);  // restarted below
        // Only the ignored flag bits set: a bare ten byte header.
        queue_header(MagicA, MagicB, MethodDeflate, 8'hc1, 0, 0, 0, 0);
        queue_noise(1);
        header_bytes = 0;

        // Random part in phases, each with its own file length, the extremes
        // among them. Every phase pauses the sender halfway until all results
        // are in. Phase 3 runs without gaps or stalls.
        for (phase = 0; phase < PhaseCount; phase++) begin
            wait_for_idle();
            case (phase)
                0:       len = '1;
                1:       len = 32'd24;
                2:       len = 32'($urandom);
                3:       len = 32'd600;
                4:       len = 32'($urandom_range(18, 64));
                default: len = '0;
            endcase
            write_file_length(len);
            gap_pct   = (phase == 3) ? 0 : 32;
            stall_pct = (phase == 3) ? 0 : 32;
            half_mark = (2 * phase + 1) * ByteTarget / (2 * PhaseCount);
            while (header_bytes < half_mark) queue_random_file();
            wait_for_idle();
            while (header_bytes < (phase + 1) * ByteTarget / PhaseCount) queue_random_file();
        end

        wait_for_idle();
        $display("Covered %0d random header bytes in %0d files under %0d file length settings.",
                 header_bytes, files_queued, PhaseCount + 1);
        $display("Results: %0d ok, %0d short file, %0d rejected (%0d header too large).",
                 status_seen[ST_OK], status_seen[ST_FILE_SHORT],
                 status_seen[ST_BAD_MAGIC] + status_seen[ST_BAD_METHOD] +
                 status_seen[ST_ENCRYPTED] + status_seen[ST_HDR_TOO_BIG],
                 status_seen[ST_HDR_TOO_BIG]);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
